// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/hgs_pkg.sv =====
// constants, types and tables of the harmonic support core
`default_nettype none

package hgs_pkg;

  localparam int WIN_LOG2     = 11;
  localparam int WINDOW       = 1 << WIN_LOG2;
  localparam int HARMONICS    = 8;
  localparam int K_W          = $clog2(HARMONICS + 1);
  localparam int SAMPLE_W     = 16;
  localparam int HZ_W         = 25;
  localparam int RATE_W       = 18;
  localparam int DB_W         = 17;
  localparam int ACC_W        = 48;
  localparam int LG_W         = 23;
  localparam int F_W          = HZ_W + K_W;
  localparam int ANG_W        = 33;
  localparam int NUM_W        = F_W + ANG_W;
  localparam int DEN_W        = RATE_W + 8;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;

  localparam logic [ANG_W-1:0] HALF_PI_Q = 33'd1686629713;
  localparam logic [ANG_W-1:0] PI_Q      = 33'd3373259426;
  localparam logic [ANG_W-1:0] TWO_PI_Q  = 33'd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN_Q = 34'sd652032874;
  localparam logic [25:0] DB_SCALE_Q16 = 26'd50504453;
  localparam logic [DB_W-1:0] DB_FLOOR_MAG = 17'd51200;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT_COS, ST_INIT_WR, ST_IDLE, ST_HARM, ST_NYQ, ST_DIV, ST_DIV_WAIT,
    ST_COS, ST_COS_WAIT, ST_G_RD, ST_G_MA, ST_G_MB, ST_G_SUM, ST_G_ACC,
    ST_P_ABS, ST_P_SH, ST_P_AB, ST_P_AA, ST_P_BB, ST_P_CA, ST_P_BT, ST_P_SUM,
    ST_L_NORM, ST_L_SQ, ST_L_DONE, ST_NEXT, ST_RESULT, ST_DB, ST_FINISH
  } st_e;

  typedef struct packed {
    logic                ring_we;
    logic                hann_we;
    logic [WIN_LOG2-1:0] addr;
    logic [SAMPLE_W-1:0] ring_data;
    logic [15:0]         hann_data;
  } mem_wr_t;

  typedef struct packed {
    logic                re;
    logic [WIN_LOG2-1:0] ring_addr;
    logic [WIN_LOG2-1:0] hann_addr;
  } mem_rd_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hgs_if.sv =====
// valid/ready channel interfaces of the harmonic support core
`default_nettype none

interface hgs_in_if import hgs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;
  logic [HZ_W-1:0]            query_hz;
  modport source (output valid, op, sample, query_hz, input ready);
  modport sink (input valid, op, sample, query_hz, output ready);
endinterface

interface hgs_cfg_if import hgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] sample_rate;
  modport source (output valid, sample_rate, input ready);
  modport sink (input valid, sample_rate, output ready);
endinterface

interface hgs_out_if import hgs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DB_W-1:0] support_db;
  logic                   no_support;
  modport source (output valid, support_db, no_support, input ready);
  modport sink (input valid, support_db, no_support, output ready);
endinterface

`default_nettype wire

// ===== rtl/hann_goertzel_harmonic_support_core.sv =====
// top level: push/query sequencer, goertzel datapath, power and log2 steps
// a push is written to the ring from idle; a query runs a goertzel pass per harmonic below nyquist
// (per sample: ring read, split multiply, sum, accumulate) and then the result, db and finish steps
// throughput: one push a cycle while idle; one query at a time, the next beat waits
// reset: a fill pass writes the hann table and clears the ring
`default_nettype none
`include "assert_macros.svh"

module hann_goertzel_harmonic_support_core import hgs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  hgs_in_if.sink           in_i,
  hgs_cfg_if.sink          cfg_i,
  hgs_out_if.source        out_o
);

  localparam int HN_W = ANG_W + WIN_LOG2 + 1;
  localparam logic signed [51:0] ACC_MAX52 = 52'sd140737488355327;
  localparam logic signed [51:0] ACC_MIN52 = -52'sd140737488355328;

  st_e state_q, state_d;

  logic [RATE_W-1:0]   rate_q;
  logic [WIN_LOG2-1:0] wpos_q, init_idx_q, j_q;
  logic [HN_W-1:0]     hn_q;
  logic [HZ_W-1:0]     hz_q;
  logic [K_W-1:0]      k_q;
  logic [F_W-1:0]      f_q;
  logic [NUM_W-1:0]    num_q;
  logic signed [31:0]  c_q;
  logic signed [ACC_W-1:0] s1_q, s2_q;
  logic signed [25:0]  x_q;
  logic [55:0]         pa_q, pb_q;
  logic [49:0]         r_q;
  logic                neg_q;
  logic [ACC_W-1:0]    m1_q, m2_q, mx_q;
  logic [4:0]          sh_q;
  logic signed [30:0]  a_q, b_q;
  logic signed [61:0]  aa_q, bb_q;
  logic signed [62:0]  ca_q;
  logic signed [63:0]  bt_q;
  logic [61:0]         p_q;
  logic [5:0]          e_q;
  logic [31:0]         y_q;
  logic [3:0]          sq_cnt_q;
  logic [15:0]         frac_q;
  logic                hf_q, ho_q, hp_q;
  logic [LG_W-1:0]     lf_q, lo_q, lp_q, d_q, lg;
  logic                res_ns_q;
  logic [DB_W-1:0]     res_db_q, db_q;
  logic                ns_q, out_valid_q;

  logic                in_ready, in_hs, out_load, cos_start, div_start, cos_done, div_done;
  logic [ANG_W-1:0]    cos_angle;
  logic signed [33:0]  cos_val;
  logic [31:0]         quo;
  mem_wr_t             wr;
  mem_rd_t             rd;
  logic [SAMPLE_W-1:0] ring_rd;
  logic [15:0]         hann_rd;

  logic signed [35:0]  hv;
  logic [15:0]         hann_val;
  logic signed [34:0]  c2;
  logic [31:0]         cm;
  logic [ACC_W-1:0]    s1m, s2m;
  logic signed [33:0]  xprod, xw;
  logic [79:0]         sum80;
  logic signed [51:0]  rs, snew;
  logic signed [ACC_W-1:0] sclamp;
  logic [29:0]         sa, sb;
  logic signed [32:0]  t33;
  logic signed [64:0]  psum;
  logic [63:0]         sqp;
  logic [32:0]         y2;
  logic [49:0]         dprod;
  logic [17:0]         mag;
  logic [LG_W-1:0]     lb;

  hgs_store u_store (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .rd_i   (rd),
    .ring_o (ring_rd),
    .hann_o (hann_rd)
  );

  hgs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cos_start),
    .angle_i (cos_angle),
    .done_o  (cos_done),
    .cos_o   (cos_val)
  );

  hgs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({rate_q, 8'b0}),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // datapath arithmetic
  always_comb begin
    hv = 36'sh040004000 - 36'(cos_val);
    hv = hv >>> 15;
    if (hv[35]) begin
      hann_val = '0;
    end else if (hv > 36'sd65535) begin
      hann_val = 16'hFFFF;
    end else begin
      hann_val = hv[15:0];
    end
    c2    = 35'(cos_val) <<< 1;
    cm    = c_q[31] ? (~c_q + 32'd1) : c_q;
    s1m   = s1_q[ACC_W-1] ? (~s1_q + ACC_W'(1)) : s1_q;
    s2m   = s2_q[ACC_W-1] ? (~s2_q + ACC_W'(1)) : s2_q;
    xprod = 34'($signed(ring_rd)) * 34'($signed({1'b0, hann_rd}));
    xw    = (xprod + 34'sd64) >>> 7;
    sum80 = {pa_q, 24'b0} + 80'(pb_q) + 80'd536870912;
    rs    = $signed({2'b00, r_q});
    rs    = neg_q ? -rs : rs;
    snew  = 52'(x_q) + rs - 52'(s2_q);
    if (snew > ACC_MAX52) begin
      sclamp = ACC_MAX52[ACC_W-1:0];
    end else if (snew < ACC_MIN52) begin
      sclamp = ACC_MIN52[ACC_W-1:0];
    end else begin
      sclamp = snew[ACC_W-1:0];
    end
    sa    = 30'(m1_q >> sh_q);
    sb    = 30'(m2_q >> sh_q);
    t33   = 33'((ca_q + 63'sd536870912) >>> 30);
    psum  = 65'(aa_q) + 65'(bb_q) - 65'(bt_q);
    sqp   = 64'(y_q) * 64'(y_q);
    y2    = sqp[63:31];
    lg    = {7'(e_q) + 7'({sh_q, 1'b0}), frac_q};
    if (!hf_q) begin
      lb = lo_q;
    end else if (!ho_q) begin
      lb = lf_q;
    end else begin
      lb = (lf_q > lo_q) ? lf_q : lo_q;
    end
    dprod = 50'(d_q) * 50'(DB_SCALE_Q16) + 50'd2147483648;
    mag   = dprod[49:32];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT_COS: state_d = ST_INIT_WR;
      ST_INIT_WR: begin
        if (cos_done) begin
          state_d = (&init_idx_q) ? ST_IDLE : ST_INIT_COS;
        end
      end
      ST_IDLE: begin
        if (in_hs && in_i.op == OP_QUERY) begin
          state_d = (rate_q == '0 || in_i.query_hz == '0) ? ST_RESULT : ST_HARM;
        end
      end
      ST_HARM: state_d = ST_NYQ;
      ST_NYQ: state_d = (f_q >= F_W'({rate_q, 7'b0})) ? ST_RESULT : ST_DIV;
      ST_DIV: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_COS;
        end
      end
      ST_COS: state_d = ST_COS_WAIT;
      ST_COS_WAIT: begin
        if (cos_done) begin
          state_d = ST_G_RD;
        end
      end
      ST_G_RD: state_d = ST_G_MA;
      ST_G_MA: state_d = ST_G_MB;
      ST_G_MB: state_d = ST_G_SUM;
      ST_G_SUM: state_d = ST_G_ACC;
      ST_G_ACC: state_d = (&j_q) ? ST_P_ABS : ST_G_RD;
      ST_P_ABS: state_d = ST_P_SH;
      ST_P_SH: begin
        if (mx_q[ACC_W-1:30] == '0) begin
          state_d = ST_P_AB;
        end
      end
      ST_P_AB: state_d = ST_P_AA;
      ST_P_AA: state_d = ST_P_BB;
      ST_P_BB: state_d = ST_P_CA;
      ST_P_CA: state_d = ST_P_BT;
      ST_P_BT: state_d = ST_P_SUM;
      ST_P_SUM: state_d = (psum > 65'sd0) ? ST_L_NORM : ST_NEXT;
      ST_L_NORM: begin
        if (p_q[61]) begin
          state_d = ST_L_SQ;
        end
      end
      ST_L_SQ: begin
        if (&sq_cnt_q) begin
          state_d = ST_L_DONE;
        end
      end
      ST_L_DONE: state_d = ST_NEXT;
      ST_NEXT: state_d = (k_q == K_W'(HARMONICS)) ? ST_RESULT : ST_HARM;
      ST_RESULT: state_d = ST_DB;
      ST_DB: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    cos_start    = 1'b0;
    div_start    = 1'b0;
    cos_angle    = {1'b0, quo};
    wr.ring_we   = 1'b0;
    wr.hann_we   = 1'b0;
    wr.addr      = wpos_q;
    wr.ring_data = in_i.sample;
    wr.hann_data = hann_val;
    rd.re        = 1'b0;
    rd.ring_addr = wpos_q + j_q;
    rd.hann_addr = j_q;
    case (state_q)
      ST_INIT_COS: begin
        cos_start = 1'b1;
        cos_angle = hn_q[HN_W-1:WIN_LOG2+1];
      end
      ST_INIT_WR: begin
        wr.ring_we   = cos_done;
        wr.hann_we   = cos_done;
        wr.addr      = init_idx_q;
        wr.ring_data = '0;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        wr.ring_we = in_i.valid && in_i.op == OP_PUSH;
      end
      ST_DIV: div_start = 1'b1;
      ST_COS: cos_start = 1'b1;
      ST_G_RD: rd.re = 1'b1;
      ST_FINISH: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_hs = in_i.valid && in_ready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_COS;
      rate_q      <= RATE_RESET;
      wpos_q      <= '0;
      init_idx_q  <= '0;
      hn_q        <= HN_W'(TWO_PI_Q) + HN_W'(WINDOW);
      out_valid_q <= 1'b0;
      hf_q        <= 1'b0;
      ho_q        <= 1'b0;
      hp_q        <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        rate_q <= cfg_i.sample_rate;
      end
      if (state_q == ST_INIT_WR && cos_done) begin
        init_idx_q <= init_idx_q + WIN_LOG2'(1);
        hn_q       <= hn_q + HN_W'({TWO_PI_Q, 1'b0});
      end
      if (in_hs && in_i.op == OP_PUSH) begin
        wpos_q <= wpos_q + WIN_LOG2'(1);
      end
      if (in_hs && in_i.op == OP_QUERY) begin
        hf_q <= 1'b0;
        ho_q <= 1'b0;
        hp_q <= 1'b0;
        k_q  <= K_W'(1);
      end
      if (state_q == ST_L_DONE) begin
        if (k_q == K_W'(1)) begin
          hf_q <= 1'b1;
        end
        if (k_q == K_W'(2)) begin
          ho_q <= 1'b1;
        end
        if (!hp_q || lg > lp_q) begin
          hp_q <= 1'b1;
        end
      end
      if (state_q == ST_NEXT && state_d == ST_HARM) begin
        k_q <= k_q + K_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: hz_q <= in_i.query_hz;
      ST_HARM: f_q <= F_W'(hz_q) * F_W'(k_q);
      ST_NYQ: num_q <= NUM_W'(f_q) * NUM_W'(TWO_PI_Q) + NUM_W'({rate_q, 7'b0});
      ST_COS_WAIT: begin
        if (c2 > 35'sd2147483647) begin
          c_q <= 32'sh7FFFFFFF;
        end else if (c2 < -35'sd2147483648) begin
          c_q <= 32'sh80000000;
        end else begin
          c_q <= c2[31:0];
        end
        s1_q <= '0;
        s2_q <= '0;
        j_q  <= '0;
      end
      ST_G_MA: begin
        x_q   <= xw[25:0];
        pa_q  <= 56'(cm) * 56'(s1m[47:24]);
        neg_q <= c_q[31] ^ s1_q[ACC_W-1];
      end
      ST_G_MB: pb_q <= 56'(cm) * 56'(s1m[23:0]);
      ST_G_SUM: r_q <= sum80[79:30];
      ST_G_ACC: begin
        s2_q <= s1_q;
        s1_q <= sclamp;
        j_q  <= j_q + WIN_LOG2'(1);
      end
      ST_P_ABS: begin
        m1_q <= s1m;
        m2_q <= s2m;
        mx_q <= (s1m > s2m) ? s1m : s2m;
        sh_q <= '0;
      end
      ST_P_SH: begin
        if (mx_q[ACC_W-1:30] != '0) begin
          mx_q <= mx_q >> 1;
          sh_q <= sh_q + 5'd1;
        end
      end
      ST_P_AB: begin
        a_q <= s1_q[ACC_W-1] ? -$signed({1'b0, sa}) : $signed({1'b0, sa});
        b_q <= s2_q[ACC_W-1] ? -$signed({1'b0, sb}) : $signed({1'b0, sb});
      end
      ST_P_AA: aa_q <= 62'(a_q) * 62'(a_q);
      ST_P_BB: bb_q <= 62'(b_q) * 62'(b_q);
      ST_P_CA: ca_q <= 63'(c_q) * 63'(a_q);
      ST_P_BT: bt_q <= 64'(b_q) * 64'(t33);
      ST_P_SUM: begin
        p_q <= psum[61:0];
        e_q <= 6'd61;
      end
      ST_L_NORM: begin
        if (p_q[61]) begin
          y_q      <= p_q[61:30];
          sq_cnt_q <= '0;
          frac_q   <= '0;
        end else begin
          p_q <= {p_q[60:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
      end
      ST_L_SQ: begin
        sq_cnt_q <= sq_cnt_q + 4'd1;
        if (y2[32]) begin
          y_q    <= y2[32:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          y_q    <= y2[31:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      ST_L_DONE: begin
        if (k_q == K_W'(1)) begin
          lf_q <= lg;
        end
        if (k_q == K_W'(2)) begin
          lo_q <= lg;
        end
        if (!hp_q || lg > lp_q) begin
          lp_q <= lg;
        end
      end
      ST_RESULT: begin
        res_ns_q <= !hp_q || (!hf_q && !ho_q);
        d_q      <= lp_q - lb;
      end
      ST_DB: begin
        if (res_ns_q || mag > 18'(DB_FLOOR_MAG)) begin
          res_db_q <= DB_W'(0) - DB_FLOOR_MAG;
        end else begin
          res_db_q <= DB_W'(0) - mag[DB_W-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      db_q <= res_db_q;
      ns_q <= res_ns_q;
    end
  end

  assign in_i.ready       = in_ready;
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.support_db = db_q;
  assign out_o.no_support = ns_q;

  `ASSERT_CLK(a_result_from_finish, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result raised outside finish")
  `ASSERT_CLK(a_query_leaves_idle, clk_i, rst_ni, (in_hs && in_i.op == OP_QUERY) |=> (state_q != ST_IDLE), "query beat left block idle")
  `ASSERT_NEVER(a_norm_nonzero, clk_i, rst_ni, (state_q == ST_L_NORM) && (p_q == '0), "log normalise on zero power")

endmodule

`default_nettype wire

// ===== rtl/hgs_store.sv =====
// sample ring and hann window memories, one write and one registered read a cycle
`default_nettype none

module hgs_store import hgs_pkg::*; (
  input  logic                clk_i,
  input  mem_wr_t             wr_i,
  input  mem_rd_t             rd_i,
  output logic [SAMPLE_W-1:0] ring_o,
  output logic [15:0]         hann_o
);

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [15:0]         hann_mem [WINDOW];
  logic [SAMPLE_W-1:0] ring_q;
  logic [15:0]         hann_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.ring_we) begin
      ring_mem[wr_i.addr] <= wr_i.ring_data;
    end
    if (wr_i.hann_we) begin
      hann_mem[wr_i.addr] <= wr_i.hann_data;
    end
    if (rd_i.re) begin
      ring_q <= ring_mem[rd_i.ring_addr];
      hann_q <= hann_mem[rd_i.hann_addr];
    end
  end

  assign ring_o = ring_q;
  assign hann_o = hann_q;

endmodule

`default_nettype wire

// ===== rtl/hgs_cordic.sv =====
// iterative rotation cordic cosine, one micro-rotation a cycle
`default_nettype none

module hgs_cordic import hgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ANG_W-1:0]    angle_i,
  output logic                done_o,
  output logic signed [33:0]  cos_o
);

  logic [ANG_W-1:0]   a_clamp, a_fold1, a_fold2;
  logic               neg_fold;
  logic signed [33:0] x_q, y_q, z_q, dx, dy, at;
  logic [STEP_W-1:0]  i_q;
  logic               busy_q, done_q, neg_q;

  always_comb begin
    a_clamp  = (angle_i > TWO_PI_Q) ? TWO_PI_Q : angle_i;
    a_fold1  = (a_clamp > PI_Q) ? (TWO_PI_Q - a_clamp) : a_clamp;
    neg_fold = a_fold1 > HALF_PI_Q;
    a_fold2  = neg_fold ? (PI_Q - a_fold1) : a_fold1;
    dx       = y_q >>> i_q;
    dy       = x_q >>> i_q;
    at       = $signed({2'b00, atan_q30(i_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + STEP_W'(1);
        if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_GAIN_Q;
      y_q   <= '0;
      z_q   <= $signed({1'b0, a_fold2});
      neg_q <= neg_fold;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;

endmodule

`default_nettype wire

// ===== rtl/hgs_divider.sv =====
// restoring divider for the harmonic angle, one quotient bit a cycle
`default_nettype none

module hgs_divider import hgs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  logic [DEN_W:0] rem_q, trial;
  logic [31:0]    low_q, quo_q;
  logic [4:0]     cnt_q;
  logic           busy_q, done_q, fits;

  always_comb begin
    trial = {rem_q[DEN_W-1:0], low_q[31]};
    fits  = trial >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (DEN_W + 1)'(num_i >> 32);
      low_q <= num_i[31:0];
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_i}) : trial;
      low_q <= {low_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
